// ----- src/fpa_pkg.sv -----
// Package with command codes and the word width for the fixed-point ALU.
package fpa_pkg;

  typedef enum logic [3:0] {
    CMD_ADD = 4'd0, CMD_SUB = 4'd1, CMD_MUL = 4'd2, CMD_DIV = 4'd3,
    CMD_GT = 4'd4, CMD_LT = 4'd5, CMD_GE = 4'd6, CMD_LE = 4'd7,
    CMD_EQ = 4'd8, CMD_NE = 4'd9, CMD_MIN = 4'd10, CMD_MAX = 4'd11,
    CMD_INC = 4'd12, CMD_DEC = 4'd13, CMD_FROM_INT = 4'd14, CMD_TO_INT = 4'd15
  } cmd_t;

  localparam int WordW = 32;

endpackage

// ----- src/fixed_point_q24_8_alu_top.sv -----
// Top level of the pipelined signed fixed-point ALU.
// One item can enter each cycle while the output is not stalled. The
// pipeline depth is set by the radix-2 restoring divider, which
// spends one stage per quotient bit over 64 bits; the simple commands
// are computed in the first stage and ride along the same pipeline. The
// multiplier forms four 16x16 partial products, registered and then summed.
// A stall holds the whole pipeline; in_tready follows out_tready or an empty
// output register.
module fixed_point_q24_8_alu_top import fpa_pkg::*; #(
  parameter int FRAC_BITS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // command[3:0], operand_a[35:4], operand_b[67:36], zeros
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // result[31:0], compare_true[32], divide_by_zero[33], zeros
);

  localparam int NStage = 64;
  localparam int DivW   = 64;

  logic adv;
  assign adv = ~out_tvalid | out_tready;
  assign in_tready = adv;

  logic [3:0] cmd_in;
  logic signed [WordW-1:0] a_in, b_in;
  assign cmd_in = in_tdata[3:0];
  assign a_in   = in_tdata[35:4];
  assign b_in   = in_tdata[67:36];

  // Stage 1: simple ops, operand preparation.
  logic               v1_r;
  logic [3:0]         cmd1_r;
  logic [WordW-1:0]   simp1_r;
  logic               cmp1_r;
  logic               dz1_r;
  logic [WordW-1:0]   ua1_r, ub1_r;
  logic               sa1_r, sb1_r;
  logic [WordW-1:0]   simp_nxt;
  logic               cmp_nxt;
  logic               lt, gt;

  assign lt = a_in < b_in;
  assign gt = a_in > b_in;

  always_comb begin
    simp_nxt = '0;
    cmp_nxt  = 1'b0;
    unique case (cmd_t'(cmd_in))
      CMD_ADD:      simp_nxt = a_in + b_in;
      CMD_SUB:      simp_nxt = a_in - b_in;
      CMD_GT:       cmp_nxt = gt;
      CMD_LT:       cmp_nxt = lt;
      CMD_GE:       cmp_nxt = ~lt;
      CMD_LE:       cmp_nxt = ~gt;
      CMD_EQ:       cmp_nxt = (a_in == b_in);
      CMD_NE:       cmp_nxt = (a_in != b_in);
      CMD_MIN:      simp_nxt = lt ? a_in : b_in;
      CMD_MAX:      simp_nxt = gt ? a_in : b_in;
      CMD_INC:      simp_nxt = a_in + 32'sd1;
      CMD_DEC:      simp_nxt = a_in - 32'sd1;
      CMD_FROM_INT: simp_nxt = a_in << FRAC_BITS;
      CMD_TO_INT:   simp_nxt = a_in >>> FRAC_BITS;
      default:      simp_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_tvalid;
    end
    if (adv) begin
      cmd1_r  <= cmd_in;
      simp1_r <= simp_nxt;
      cmp1_r  <= cmp_nxt;
      dz1_r   <= (cmd_t'(cmd_in) == CMD_DIV) && (b_in == '0);
      sa1_r   <= a_in[WordW-1];
      sb1_r   <= b_in[WordW-1];
      ua1_r   <= a_in[WordW-1] ? WordW'(-a_in) : a_in;
      ub1_r   <= b_in[WordW-1] ? WordW'(-b_in) : b_in;
    end
  end

  // Stage 2: unsigned 32x32 multiply as four 16x16 partial products.
  logic [31:0] pp_ll_r, pp_lh_r, pp_hl_r, pp_hh_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      pp_ll_r <= ua1_r[15:0]  * ub1_r[15:0];
      pp_lh_r <= ua1_r[15:0]  * ub1_r[31:16];
      pp_hl_r <= ua1_r[31:16] * ub1_r[15:0];
      pp_hh_r <= ua1_r[31:16] * ub1_r[31:16];
    end
  end

  // Stage 3: sum partial products, restore sign, shift.
  logic [63:0] mag;
  logic [63:0] prod_s;
  logic [63:0] mul_nxt;
  logic        v2_r;
  logic [3:0]  cmd2_r;
  logic [WordW-1:0] simp2_r;
  logic        cmp2_r, dz2_r, neg2_r;
  logic [WordW-1:0] ua2_r, ub2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (adv) v2_r <= v1_r;
    if (adv) begin
      cmd2_r  <= cmd1_r;
      simp2_r <= simp1_r;
      cmp2_r  <= cmp1_r;
      dz2_r   <= dz1_r;
      neg2_r  <= sa1_r ^ sb1_r;
      ua2_r   <= ua1_r;
      ub2_r   <= ub1_r;
    end
  end

  assign mag = {32'd0, pp_ll_r} + {16'd0, pp_lh_r, 16'd0} + {16'd0, pp_hl_r, 16'd0}
             + {pp_hh_r, 32'd0};
  assign prod_s  = neg2_r ? -mag : mag;
  assign mul_nxt = $signed(prod_s) >>> FRAC_BITS;

  // Divider stages: restoring radix-2, one quotient bit per stage.
  logic [NStage:0]            dv_r;
  logic [3:0]                 dcmd_r  [NStage+1];
  logic [WordW-1:0]           dsimp_r [NStage+1];
  logic                       dcmp_r  [NStage+1];
  logic                       ddz_r   [NStage+1];
  logic                       dneg_r  [NStage+1];
  logic [DivW-1:0]            dnum_r  [NStage+1];
  logic [WordW:0]             drem_r  [NStage+1];
  logic [WordW-1:0]           dden_r  [NStage+1];
  logic [WordW-1:0]           dmul_r  [NStage+1];

  always_ff @(posedge clk) begin
    if (!rst_n) dv_r[0] <= 1'b0;
    else if (adv) dv_r[0] <= v2_r;
    if (adv) begin
      dcmd_r[0]  <= cmd2_r;
      dsimp_r[0] <= simp2_r;
      dcmp_r[0]  <= cmp2_r;
      ddz_r[0]   <= dz2_r;
      dneg_r[0]  <= neg2_r;
      dnum_r[0]  <= {{(DivW-WordW){1'b0}}, ua2_r} << FRAC_BITS;
      drem_r[0]  <= '0;
      dden_r[0]  <= ub2_r;
      dmul_r[0]  <= mul_nxt[WordW-1:0];
    end
  end

  for (genvar i = 0; i < NStage; i++) begin : g_div
    logic [WordW+1:0] trial;
    logic [WordW:0]   rsh;
    assign rsh   = {drem_r[i][WordW-1:0], dnum_r[i][DivW-1]};
    assign trial = {1'b0, rsh} - {2'b0, dden_r[i]};
    always_ff @(posedge clk) begin
      if (!rst_n) dv_r[i+1] <= 1'b0;
      else if (adv) dv_r[i+1] <= dv_r[i];
      if (adv) begin
        dcmd_r[i+1]  <= dcmd_r[i];
        dsimp_r[i+1] <= dsimp_r[i];
        dcmp_r[i+1]  <= dcmp_r[i];
        ddz_r[i+1]   <= ddz_r[i];
        dneg_r[i+1]  <= dneg_r[i];
        dden_r[i+1]  <= dden_r[i];
        dmul_r[i+1]  <= dmul_r[i];
        drem_r[i+1]  <= trial[WordW+1] ? rsh : trial[WordW:0];
        dnum_r[i+1]  <= {dnum_r[i][DivW-2:0], ~trial[WordW+1]};
      end
    end
  end

  // Output register.
  logic [WordW-1:0] q_abs, q_s, res_nxt;
  logic [WordW-1:0] res_r;
  logic             cmpo_r, dzo_r;
  assign q_abs = dnum_r[NStage][WordW-1:0];
  assign q_s   = dneg_r[NStage] ? -q_abs : q_abs;

  always_comb begin
    unique case (cmd_t'(dcmd_r[NStage]))
      CMD_MUL: res_nxt = dmul_r[NStage];
      CMD_DIV: res_nxt = ddz_r[NStage] ? '0 : q_s;
      default: res_nxt = dsimp_r[NStage];
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_tvalid <= 1'b0;
    else if (adv) out_tvalid <= dv_r[NStage];
    if (adv) begin
      res_r  <= res_nxt;
      cmpo_r <= dcmp_r[NStage];
      dzo_r  <= ddz_r[NStage];
    end
  end

  assign out_tdata = {6'd0, dzo_r, cmpo_r, res_r};

  a_dz_only_div: assert property (@(posedge clk) disable iff (!rst_n)
    dv_r[NStage] && ddz_r[NStage] |-> cmd_t'(dcmd_r[NStage]) == CMD_DIV)
    else $error("divide-by-zero flag on a non-divide item");
  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[32] && out_tdata[33]))
    else $error("compare and divide-by-zero flags both set");
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(dv_r))
    else $error("pipeline moved during stall");

endmodule

// ----- dv/fixed_point_q24_8_alu_top_tb.sv -----
// Self-checking testbench for the fixed-point ALU: directed and random items, scoreboard checks.
`timescale 1ns / 1ps

module fixed_point_q24_8_alu_top_tb;
  import fpa_pkg::*;

  localparam int FracBits = 8;
  localparam int Latency = 67;
  localparam int LimitCycles = 400000;
  localparam int HoldOffCycles = 300;

  typedef struct packed {
    cmd_t command;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } alu_op_t;

  typedef struct packed {
    logic [31:0] result;
    logic compare_true;
    logic divide_by_zero;
  } alu_res_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [71:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [39:0] out_tdata;

  alu_op_t pending_ops[$];
  alu_res_t expected_results[$];
  int send_idle_pct;
  int recv_stall_pct;
  bit hold_off_go;
  logic hold_off;
  int error_count = 0;
  int result_count = 0;
  int cycle_count = 0;

  fixed_point_q24_8_alu_top #(.FRAC_BITS(FracBits)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic alu_res_t compute_alu(alu_op_t op);
    alu_res_t r;
    logic signed [63:0] a64;
    logic signed [63:0] b64;
    logic signed [63:0] wide;
    r = '0;
    a64 = op.operand_a;
    b64 = op.operand_b;
    case (op.command)
      CMD_ADD: r.result = op.operand_a + op.operand_b;
      CMD_SUB: r.result = op.operand_a - op.operand_b;
      CMD_MUL: begin
        wide = a64 * b64;
        wide = wide >>> FracBits;
        r.result = wide[31:0];
      end
      CMD_DIV: begin
        if (op.operand_b == 0) begin
          r.divide_by_zero = 1'b1;
        end else begin
          wide = (a64 <<< FracBits) / b64;
          r.result = wide[31:0];
        end
      end
      CMD_GT: r.compare_true = op.operand_a > op.operand_b;
      CMD_LT: r.compare_true = op.operand_a < op.operand_b;
      CMD_GE: r.compare_true = op.operand_a >= op.operand_b;
      CMD_LE: r.compare_true = op.operand_a <= op.operand_b;
      CMD_EQ: r.compare_true = op.operand_a == op.operand_b;
      CMD_NE: r.compare_true = op.operand_a != op.operand_b;
      CMD_MIN: r.result = (op.operand_a < op.operand_b) ? op.operand_a : op.operand_b;
      CMD_MAX: r.result = (op.operand_a > op.operand_b) ? op.operand_a : op.operand_b;
      CMD_INC: r.result = op.operand_a + 1;
      CMD_DEC: r.result = op.operand_a - 1;
      CMD_FROM_INT: r.result = op.operand_a <<< FracBits;
      default: r.result = op.operand_a >>> FracBits;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: %s mismatch: got %h expected %h", $time, what, got, want);
    error_count++;
  endtask

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0;
      3: return $urandom_range(0, 1) ? 32'hffff_ffff : 32'h1;
      4: return $signed($urandom_range(0, 2047)) - 1024;
      5: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  task automatic add_op(input cmd_t c, input logic [31:0] a, input logic [31:0] b);
    alu_op_t op;
    op.command = c;
    op.operand_a = a;
    op.operand_b = b;
    pending_ops.push_back(op);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
    end else if (!in_tvalid || in_tready) begin
      if (pending_ops.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        alu_op_t op;
        op = pending_ops.pop_front();
        expected_results.push_back(compute_alu(op));
        in_tvalid <= 1'b1;
        in_tdata <= {4'b0, op.operand_b, op.operand_a, op.command};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // The long hold-off of the receiver is timed here.
  initial begin
    hold_off = 1'b0;
    wait (hold_off_go);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HoldOffCycles) @(posedge clk);
    hold_off <= 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_off) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      alu_res_t want;
      result_count++;
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected item", out_tdata[31:0], 32'h0);
      end else begin
        want = expected_results.pop_front();
        if (out_tdata[31:0] !== want.result)
          report_mismatch("result", out_tdata[31:0], want.result);
        if (out_tdata[32] !== want.compare_true)
          report_mismatch("compare_true", 32'(out_tdata[32]), 32'(want.compare_true));
        if (out_tdata[33] !== want.divide_by_zero)
          report_mismatch("divide_by_zero", 32'(out_tdata[33]), 32'(want.divide_by_zero));
        if (out_tdata[39:34] !== 6'b0)
          report_mismatch("padding", 32'(out_tdata[39:34]), 32'h0);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LimitCycles) begin
      $display("Timed out with %0d results still expected.", expected_results.size());
      $display("fixed_point_q24_8_alu_top_tb: FAIL");
      $finish;
    end
  end

  task automatic run_phase(input int n, input int idle, input int stall);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (int i = 0; i < n; i++)
      add_op(cmd_t'($urandom_range(0, 15)), pick_operand(), pick_operand());
    wait (pending_ops.size() == 0);
  endtask

  initial begin
    logic [31:0] edges[6];
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off_go = 1'b0;
    rst_n = 1'b0;
    edges = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h1, 32'hffff_ffff, 32'h0000_0100};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    for (int c = 0; c < 16; c++)
      add_op(cmd_t'(c), edges[c % 6], edges[(c + 2) % 6]);
    add_op(CMD_DIV, 32'h1234_5678, 32'h0);
    add_op(CMD_DIV, 32'h8000_0000, 32'hffff_ffff);
    add_op(CMD_DIV, 32'h7fff_ffff, 32'h0000_0001);
    add_op(CMD_MUL, 32'h8000_0000, 32'h8000_0000);
    add_op(CMD_MUL, 32'h7fff_ffff, 32'h7fff_ffff);
    add_op(CMD_EQ, 32'h5555_5555, 32'h5555_5555);
    add_op(CMD_INC, 32'h7fff_ffff, 32'hffff_ffff);
    add_op(CMD_DEC, 32'h8000_0000, 32'h0);
    wait (pending_ops.size() == 0);

    run_phase(400, 0, 0);
    // Receiver holds off while the sender keeps offering, so the pipeline fills.
    hold_off_go = 1'b1;
    run_phase(300, 0, 0);
    run_phase(250, 88, 0);
    run_phase(250, 0, 88);
    run_phase(350, 32, 32);

    wait (pending_ops.size() == 0 && expected_results.size() == 0);
    repeat (Latency + 10) @(posedge clk);
    $display("Checked %0d results over all 16 commands, edge operands and divide by zero,",
             result_count);
    $display("under idle, stall, long hold-off and mixed flow control.");
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("fixed_point_q24_8_alu_top_tb: PASS");
    end else begin
      $display("fixed_point_q24_8_alu_top_tb: FAIL");
    end
    $finish;
  end

endmodule
